// ----- design/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants of the daylight dimming sequencer
// Controller states, command and status bundles, register indexes and the
// brightness curve.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RISE_HOUR = 3'd0,
    CFG_RISE_MIN  = 3'd1,
    CFG_RISE_SEC  = 3'd2,
    CFG_SET_HOUR  = 3'd3,
    CFG_SET_MIN   = 3'd4,
    CFG_SET_SEC   = 3'd5,
    CFG_SEC_TICK  = 3'd6,
    CFG_TICK_DAY  = 3'd7
  } dds_cfg_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Time of day in seconds, taken at face value from 5/6/6-bit fields
  localparam int TIME_W        = 17;
  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;

  // Segment arithmetic
  localparam int SEG_W     = 6;
  localparam int SEG_COUNT = 39;
  localparam int SEG_FOLD  = 20;
  localparam int IDX_W     = 5;
  localparam int LO_W      = 18;
  localparam int SEGLEN_W  = 12;

  // Divide by 39 for values below 2^17: q = (x * RECIP) >> RECIP_SHIFT
  localparam int RECIP       = 215093;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 18;
  localparam int RPROD_W     = TIME_W + RECIP_W;

  localparam int DUTY_W = 10;
  localparam int SIM_W  = 32;
  localparam int SAT_W  = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BASE,
    ST_SEARCH,
    ST_OUT
  } dds_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic base;
    logic step;
    logic emit;
  } dds_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } dds_stat_t;

  // Brightness curve, 1023 darkest
  function automatic logic [DUTY_W-1:0] duty_curve(input logic [IDX_W-1:0] idx);
    logic [DUTY_W-1:0] d;
    case (idx)
      5'd0:    d = 10'd1023;
      5'd1:    d = 10'd790;
      5'd2:    d = 10'd654;
      5'd3:    d = 10'd557;
      5'd4:    d = 10'd482;
      5'd5:    d = 10'd421;
      5'd6:    d = 10'd369;
      5'd7:    d = 10'd324;
      5'd8:    d = 10'd285;
      5'd9:    d = 10'd249;
      5'd10:   d = 10'd217;
      5'd11:   d = 10'd188;
      5'd12:   d = 10'd161;
      5'd13:   d = 10'd136;
      5'd14:   d = 10'd113;
      5'd15:   d = 10'd91;
      5'd16:   d = 10'd71;
      5'd17:   d = 10'd52;
      5'd18:   d = 10'd33;
      5'd19:   d = 10'd16;
      5'd20:   d = 10'd0;
      default: d = 10'd1023;
    endcase
    return d;
  endfunction

  // Fold segments above the midpoint back onto the curve
  function automatic logic [IDX_W-1:0] fold_seg(input logic [SEG_W-1:0] seg);
    logic [SEG_W-1:0] f;
    if (seg > SEG_W'(SEG_FOLD)) begin
      f = SEG_W'(SEG_COUNT) - seg;
    end else begin
      f = seg;
    end
    return f[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/dds_in_if.sv -----
// ----------------------------------------------------------------------------
// dds_in_if: tick input channel
// Valid/ready channel carrying the restart flag of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface dds_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ----- design/dds_out_if.sv -----
// ----------------------------------------------------------------------------
// dds_out_if: result output channel
// Valid/ready channel carrying duty, segment, daylight flag and scaled time.
// ----------------------------------------------------------------------------
`default_nettype none

interface dds_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pwm_duty;
  logic [5:0]  segment_now;
  logic        in_daylight;
  logic [31:0] sim_time;

  modport source (output valid, output pwm_duty, output segment_now,
                  output in_daylight, output sim_time, input ready);
  modport sink   (input valid, input pwm_duty, input segment_now,
                  input in_daylight, input sim_time, output ready);
endinterface

`default_nettype wire

// ----- design/dds_ctrl.sv -----
// ----------------------------------------------------------------------------
// dds_ctrl: sequencer controller
// Walks one tick through multiply, divide, base, search and output steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  dds_pkg::dds_stat_t  stat_i,
  output dds_pkg::dds_cmd_t   cmd_o
);
  import dds_pkg::*;

  dds_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    state_d = ST_BASE;
      ST_BASE:   state_d = ST_SEARCH;
      ST_SEARCH: if (stat_i.hit) state_d = ST_OUT;
      ST_OUT:    if (!stat_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:    cmd_o.mul  = 1'b1;
      ST_DIV:    cmd_o.div  = 1'b1;
      ST_BASE:   cmd_o.base = 1'b1;
      ST_SEARCH: cmd_o.step = !stat_i.hit;
      ST_OUT:    cmd_o.emit = !stat_i.out_busy;
      default:   cmd_o      = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/dds_dpath.sv -----
// ----------------------------------------------------------------------------
// dds_dpath: sequencer datapath
// Config registers, tick counter, scaled time, segment search and result.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_dpath #(
  parameter int TICK_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          restart_i,
  input  dds_pkg::dds_cmd_t                  cmd_i,
  output dds_pkg::dds_stat_t                 stat_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [dds_pkg::DUTY_W-1:0]         pwm_duty_o,
  output logic [dds_pkg::SEG_W-1:0]          segment_now_o,
  output logic                               in_daylight_o,
  output logic [dds_pkg::SIM_W-1:0]          sim_time_o
);
  import dds_pkg::*;

  localparam int PROD_W = TICK_BITS + CFG_DATA_W;
  localparam int CNT_W  = (TICK_BITS > CFG_DATA_W) ? TICK_BITS : CFG_DATA_W;

  // Configuration
  logic [4:0]            rise_h_q, set_h_q;
  logic [5:0]            rise_m_q, rise_s_q, set_m_q, set_s_q;
  logic [CFG_DATA_W-1:0] spt_q, tpd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_h_q <= 5'd7;
      rise_m_q <= '0;
      rise_s_q <= '0;
      set_h_q  <= 5'd21;
      set_m_q  <= '0;
      set_s_q  <= '0;
      spt_q    <= 16'd60;
      tpd_q    <= 16'd1440;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RISE_HOUR: rise_h_q <= cfg_data_i[4:0];
        CFG_RISE_MIN:  rise_m_q <= cfg_data_i[5:0];
        CFG_RISE_SEC:  rise_s_q <= cfg_data_i[5:0];
        CFG_SET_HOUR:  set_h_q  <= cfg_data_i[4:0];
        CFG_SET_MIN:   set_m_q  <= cfg_data_i[5:0];
        CFG_SET_SEC:   set_s_q  <= cfg_data_i[5:0];
        CFG_SEC_TICK:  spt_q    <= cfg_data_i;
        CFG_TICK_DAY:  tpd_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // State
  logic [TICK_BITS-1:0] tick_q;
  logic [SEG_W-1:0]     seg_q;
  logic                 out_valid_q;

  // Work registers
  logic [PROD_W-1:0]   prod_q;
  logic [TIME_W-1:0]   rise_q, set_q;
  logic [SIM_W-1:0]    t_q;
  logic                day_q;
  logic [RPROD_W-1:0]  rprod_q;
  logic [SEGLEN_W-1:0] seglen_q;
  logic [LO_W-1:0]     lo_q;

  // Result registers
  logic [DUTY_W-1:0] duty_q;
  logic [SEG_W-1:0]  seg_out_q;
  logic              day_out_q;
  logic [SIM_W-1:0]  t_out_q;

  logic [TIME_W-1:0]    rise_d, set_d, diff;
  logic [SAT_W-1:0]     prod_ext;
  logic [SIM_W-1:0]     t_sat;
  logic [SEGLEN_W-1:0]  seglen_d;
  logic [LO_W-1:0]      hi;
  logic                 hit;
  logic [SEG_W-1:0]     seg_fin;
  logic [TICK_BITS-1:0] tick_inc;
  logic                 tick_wrap;

  always_comb begin
    rise_d = TIME_W'(rise_h_q) * TIME_W'(SEC_PER_HOUR) +
             TIME_W'(rise_m_q) * TIME_W'(SEC_PER_MIN) + TIME_W'(rise_s_q);
    set_d  = TIME_W'(set_h_q) * TIME_W'(SEC_PER_HOUR) +
             TIME_W'(set_m_q) * TIME_W'(SEC_PER_MIN) + TIME_W'(set_s_q);
    prod_ext = SAT_W'(prod_q);
    t_sat    = (|prod_ext[SAT_W-1:SIM_W]) ? '1 : prod_ext[SIM_W-1:0];
    diff     = set_q - rise_q;
    seglen_d = rprod_q[RPROD_W-1:RECIP_SHIFT];
    hi       = lo_q + LO_W'(seglen_q);
    hit      = !day_q || (seg_q >= SEG_W'(SEG_COUNT)) ||
               ((t_q >= SIM_W'(lo_q)) && (t_q <= SIM_W'(hi)));
    seg_fin  = day_q ? seg_q : '0;
    tick_inc  = tick_q + 1'b1;
    tick_wrap = (CNT_W'(tick_inc) == CNT_W'(tpd_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && restart_i) begin
        tick_q <= '0;
        seg_q  <= '0;
      end else if (cmd_i.step) begin
        seg_q <= seg_q + 1'b1;
      end else if (cmd_i.emit) begin
        seg_q  <= seg_fin;
        tick_q <= tick_wrap ? '0 : tick_inc;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(tick_q) * PROD_W'(spt_q);
      rise_q <= rise_d;
      set_q  <= set_d;
    end
    if (cmd_i.div) begin
      t_q     <= t_sat;
      day_q   <= (t_sat >= SIM_W'(rise_q)) && (t_sat <= SIM_W'(set_q));
      rprod_q <= RPROD_W'(diff) * RPROD_W'(RECIP);
    end
    if (cmd_i.base) begin
      seglen_q <= seglen_d;
      lo_q     <= LO_W'(rise_q) + LO_W'(seg_q) * LO_W'(seglen_d);
    end
    if (cmd_i.step) begin
      lo_q <= hi;
    end
    if (cmd_i.emit) begin
      duty_q    <= duty_curve(fold_seg(seg_fin));
      seg_out_q <= seg_fin;
      day_out_q <= day_q;
      t_out_q   <= t_q;
    end
  end

  assign stat_o.hit      = hit;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pwm_duty_o    = duty_q;
  assign segment_now_o = seg_out_q;
  assign in_daylight_o = day_out_q;
  assign sim_time_o    = t_out_q;

endmodule

`default_nettype wire

// ----- design/daylight_dimming_sequencer_unit.sv -----
// Each tick transfer runs through the multiply, divide, base, search and output states; the
// search advances one segment per step until the time falls in it (at most 39 steps).
// A new tick is taken only after the previous one is emitted; the search and a stalled output hold it off.
// A finished result waits in the output register while the next tick is taken.
// Reset (rst_ni low, async): counter and segment cleared, registers to 7:00:00,
// 21:00:00, 60 s per tick, 1440 ticks per day; no result pending.
// ----------------------------------------------------------------------------
// daylight_dimming_sequencer_unit: simulated-day PWM dimming sequencer
// Scales a tick counter to time of day, tracks the daylight segment and maps
// it through a brightness curve to a 10-bit duty.
// ----------------------------------------------------------------------------
`default_nettype none

module daylight_dimming_sequencer_unit #(
  parameter int TICK_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dds_in_if.sink                              in_i,
  dds_out_if.source                           out_o
);
  import dds_pkg::*;

  dds_cmd_t  cmd;
  dds_stat_t stat;

  // Controller: one transfer in, then multiply, divide, base, search, emit
  dds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: holds config, tick counter, segment and the output register
  dds_dpath #(
    .TICK_BITS (TICK_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .restart_i     (in_i.restart),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pwm_duty_o    (out_o.pwm_duty),
    .segment_now_o (out_o.segment_now),
    .in_daylight_o (out_o.in_daylight),
    .sim_time_o    (out_o.sim_time)
  );

endmodule

`default_nettype wire
